### sv/cdd_pkg.sv
// Shared types, constants and helpers for the controller delta decoder.
`default_nettype none

package cdd_pkg;

  localparam int unsigned MASK_W = 6;
  localparam int unsigned SLOT_N = 8;

  // Payload slot positions, in stream order.
  localparam int unsigned SLOT_LT  = 0;
  localparam int unsigned SLOT_RT  = 1;
  localparam int unsigned SLOT_LX  = 2;
  localparam int unsigned SLOT_LY  = 3;
  localparam int unsigned SLOT_RX  = 4;
  localparam int unsigned SLOT_RY  = 5;
  localparam int unsigned SLOT_DIR = 6;
  localparam int unsigned SLOT_OTH = 7;

  // Header flag positions.
  localparam int unsigned HDR_LT    = 0;
  localparam int unsigned HDR_RT    = 1;
  localparam int unsigned HDR_LS    = 2;
  localparam int unsigned HDR_RS    = 3;
  localparam int unsigned HDR_DIR   = 4;
  localparam int unsigned HDR_OTHER = 5;

  typedef logic [MASK_W-1:0] hdr_mask_t;
  typedef logic [SLOT_N-1:0] slot_vec_t;

  typedef struct packed {
    logic [7:0] left_trigger;
    logic [7:0] right_trigger;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] direction_buttons;
    logic [6:0] other_buttons;
  } pad_state_t;

  // One bit per expected payload byte; sticks take two bytes each.
  function automatic slot_vec_t expand_slots(input hdr_mask_t m);
    slot_vec_t s;
    s[SLOT_LT]  = m[HDR_LT];
    s[SLOT_RT]  = m[HDR_RT];
    s[SLOT_LX]  = m[HDR_LS];
    s[SLOT_LY]  = m[HDR_LS];
    s[SLOT_RX]  = m[HDR_RS];
    s[SLOT_RY]  = m[HDR_RS];
    s[SLOT_DIR] = m[HDR_DIR];
    s[SLOT_OTH] = m[HDR_OTHER];
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/controller_delta_decoder.sv
// Top level of the controller delta decoder.
// Takes one stream byte per cycle and, when a message completes, presents the
// whole stored controller state with the header mask of that message. Bytes
// are registered on entry, then decoded and stored when the result side is
// free, and a completed result is registered for the out_ port; the rate is
// one byte per cycle as long as results are taken, and the input only stalls
// while a finished result waits and the entry register is full.
`default_nettype none

module controller_delta_decoder import cdd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_left_trigger,
  output logic [7:0]      out_right_trigger,
  output logic [7:0]      out_left_stick_x,
  output logic [7:0]      out_left_stick_y,
  output logic [7:0]      out_right_stick_x,
  output logic [7:0]      out_right_stick_y,
  output logic [7:0]      out_direction_buttons,
  output logic [6:0]      out_other_buttons,
  output logic [5:0]      out_updated_mask
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       out_free;
  logic       step;
  logic       emit;
  hdr_mask_t  emit_mask;
  pad_state_t st_next;
  pad_state_t st_out;
  hdr_mask_t  mask_out;

  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_comb begin
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
    end
  end

  cdd_field_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .data_i  (s1_data_r),
    .emit_o  (emit),
    .mask_o  (emit_mask),
    .state_o (st_next)
  );

  cdd_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (emit),
    .state_i (st_next),
    .mask_i  (emit_mask),
    .ready_i (out_ready),
    .valid_o (out_valid),
    .free_o  (out_free),
    .state_o (st_out),
    .mask_o  (mask_out)
  );

  assign out_left_trigger      = st_out.left_trigger;
  assign out_right_trigger     = st_out.right_trigger;
  assign out_left_stick_x      = st_out.left_stick_x;
  assign out_left_stick_y      = st_out.left_stick_y;
  assign out_right_stick_x     = st_out.right_stick_x;
  assign out_right_stick_y     = st_out.right_stick_y;
  assign out_direction_buttons = st_out.direction_buttons;
  assign out_other_buttons     = st_out.other_buttons;
  assign out_updated_mask      = mask_out;

endmodule

`default_nettype wire

### sv/cdd_field_store.sv
// Message framing and the stored controller fields.
`default_nettype none

module cdd_field_store import cdd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_i,
  input  wire logic [7:0] data_i,
  output logic            emit_o,
  output hdr_mask_t       mask_o,
  output pad_state_t      state_o
);

  pad_state_t st_r, st_nxt;
  slot_vec_t  slots_r, slots_nxt;
  hdr_mask_t  mask_r, mask_nxt;
  slot_vec_t  pick;
  hdr_mask_t  hdr;

  always_comb begin
    st_nxt    = st_r;
    slots_nxt = slots_r;
    mask_nxt  = mask_r;
    emit_o    = 1'b0;
    mask_o    = mask_r;
    hdr       = data_i[MASK_W-1:0];
    // lowest outstanding slot gets this byte
    pick      = slots_r & (~slots_r + slot_vec_t'(1));
    if (step_i) begin
      if (slots_r == '0) begin
        mask_nxt  = hdr;
        slots_nxt = expand_slots(hdr);
        if (hdr == '0) begin
          emit_o = 1'b1;
          mask_o = '0;
        end
      end else begin
        if (pick[SLOT_LT])  st_nxt.left_trigger      = data_i;
        if (pick[SLOT_RT])  st_nxt.right_trigger     = data_i;
        if (pick[SLOT_LX])  st_nxt.left_stick_x      = data_i;
        if (pick[SLOT_LY])  st_nxt.left_stick_y      = data_i;
        if (pick[SLOT_RX])  st_nxt.right_stick_x     = data_i;
        if (pick[SLOT_RY])  st_nxt.right_stick_y     = data_i;
        if (pick[SLOT_DIR]) st_nxt.direction_buttons = data_i;
        if (pick[SLOT_OTH]) st_nxt.other_buttons     = data_i[6:0];
        slots_nxt = slots_r & ~pick;
        if (slots_nxt == '0) begin
          emit_o   = 1'b1;
          mask_nxt = '0;
        end
      end
    end
    state_o = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      slots_r <= '0;
      mask_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      slots_r <= slots_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/cdd_out_reg.sv
// Result register holding one decoded controller snapshot.
`default_nettype none

module cdd_out_reg import cdd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_i,
  input  wire pad_state_t state_i,
  input  wire hdr_mask_t  mask_i,
  input  wire logic       ready_i,
  output logic            valid_o,
  output logic            free_o,
  output pad_state_t      state_o,
  output hdr_mask_t       mask_o
);

  logic       valid_r, valid_nxt;
  pad_state_t state_r;
  hdr_mask_t  mask_r;

  assign free_o = !valid_r || ready_i;

  always_comb begin
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (ready_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      state_r <= state_i;
      mask_r  <= mask_i;
    end
  end

  assign valid_o = valid_r;
  assign state_o = state_r;
  assign mask_o  = mask_r;

endmodule

`default_nettype wire

### sv/cdd_checker.sv
// Port-level checks for the controller delta decoder, bound to the top level.
`default_nettype none

module cdd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_left_trigger,
  input wire logic [7:0] out_direction_buttons,
  input wire logic [5:0] out_updated_mask
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_trigger)
      && $stable(out_direction_buttons) && $stable(out_updated_mask))
    else $error("result changed while stalled");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

  // input only backs up behind a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result side free");

  // a new result follows an earlier accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a causing item");

endmodule

bind controller_delta_decoder cdd_checker u_cdd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_left_trigger      (out_left_trigger),
  .out_direction_buttons (out_direction_buttons),
  .out_updated_mask      (out_updated_mask)
);

`default_nettype wire

### tb/controller_delta_decoder_tb.sv
// Self-checking testbench for the controller delta decoder: directed table plus random messages.
`timescale 1ns / 100ps

module controller_delta_decoder_tb import cdd_pkg::*; ();

  localparam int unsigned BYTE_GOAL   = 1950;
  localparam int unsigned TAIL_START  = 1700;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned DIR_N       = 25;

  typedef struct packed {
    pad_state_t pad;
    hdr_mask_t  mask;
  } pad_report_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    pad_report_t want;
  } stim_row_t;

  localparam pad_report_t REPORT_RESET   = '0;
  localparam pad_report_t REPORT_FULL    = '{
    pad: '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F}, mask: 6'h3F};
  localparam pad_report_t REPORT_CLEARED = '{pad: '0, mask: 6'h3F};
  localparam pad_report_t UNTYPED        = '0;

  // Header bit that enables each payload slot, in stream order.
  localparam int unsigned SLOT_HDR [SLOT_N] = '{HDR_LT, HDR_RT, HDR_LS, HDR_LS,
                                                HDR_RS, HDR_RS, HDR_DIR, HDR_OTHER};

  stim_row_t directed_rows [DIR_N] = '{
    '{8'h00, 1'b1, REPORT_RESET},    // empty header right after reset
    '{8'hC0, 1'b1, REPORT_RESET},    // only the ignored header bits
    '{8'hFF, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, UNTYPED}, '{8'hFF, 1'b0, UNTYPED}, '{8'hFF, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, UNTYPED}, '{8'hFF, 1'b0, UNTYPED}, '{8'hFF, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, UNTYPED},
    '{8'hFF, 1'b1, REPORT_FULL},     // other button bit 7 dropped
    '{8'h3F, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED}, '{8'h00, 1'b0, UNTYPED},
    '{8'h00, 1'b0, UNTYPED},
    '{8'h80, 1'b1, REPORT_CLEARED},
    '{8'h20, 1'b0, UNTYPED},
    '{8'hAB, 1'b0, UNTYPED},
    '{8'h04, 1'b0, UNTYPED},
    '{8'h12, 1'b0, UNTYPED},
    '{8'h34, 1'b0, UNTYPED}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_left_trigger;
  logic [7:0] out_right_trigger;
  logic [7:0] out_left_stick_x;
  logic [7:0] out_left_stick_y;
  logic [7:0] out_right_stick_x;
  logic [7:0] out_right_stick_y;
  logic [7:0] out_direction_buttons;
  logic [6:0] out_other_buttons;
  logic [5:0] out_updated_mask;

  // decoder model state
  pad_state_t  pad_model;
  hdr_mask_t   open_mask;
  logic [3:0]  byte_pos;

  pad_report_t pending_reports [$];
  int unsigned bytes_sent;
  int unsigned reports_checked;
  int unsigned messages_sent;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned ready_hold;
  bit          tail_phase;
  bit          link_quiet;

  controller_delta_decoder DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_trigger      (out_left_trigger),
    .out_right_trigger     (out_right_trigger),
    .out_left_stick_x      (out_left_stick_x),
    .out_left_stick_y      (out_left_stick_y),
    .out_right_stick_x     (out_right_stick_x),
    .out_right_stick_y     (out_right_stick_y),
    .out_direction_buttons (out_direction_buttons),
    .out_other_buttons     (out_other_buttons),
    .out_updated_mask      (out_updated_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the decoder model by one stream byte; done flags a completed message.
  task automatic decode_byte(input logic [7:0] b, output bit done, output pad_report_t rep);
    int unsigned total;
    int unsigned target;
    done = 1'b0;
    rep  = '0;
    if (byte_pos == 0) begin
      if (b[5:0] == 0) begin
        done = 1'b1;
        rep  = '{pad: pad_model, mask: '0};
      end else begin
        open_mask = b[5:0];
        byte_pos  = 4'd1;
      end
    end else begin
      total  = 0;
      target = SLOT_N;
      for (int s = 0; s < SLOT_N; s++) begin
        if (open_mask[SLOT_HDR[s]]) begin
          if (total + 1 == byte_pos) target = s;
          total++;
        end
      end
      unique case (target)
        SLOT_LT:  pad_model.left_trigger      = b;
        SLOT_RT:  pad_model.right_trigger     = b;
        SLOT_LX:  pad_model.left_stick_x      = b;
        SLOT_LY:  pad_model.left_stick_y      = b;
        SLOT_RX:  pad_model.right_stick_x     = b;
        SLOT_RY:  pad_model.right_stick_y     = b;
        SLOT_DIR: pad_model.direction_buttons = b;
        SLOT_OTH: pad_model.other_buttons     = b[6:0];
        default: ;
      endcase
      if (byte_pos >= total) begin
        done      = 1'b1;
        rep       = '{pad: pad_model, mask: open_mask};
        byte_pos  = '0;
        open_mask = '0;
      end else begin
        byte_pos = byte_pos + 4'd1;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input pad_report_t want);
    bit          done;
    pad_report_t rep;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, done, rep);
    if (done) begin
      pending_reports.push_back(typed ? want : rep);
      messages_sent++;
    end
    bytes_sent++;
    if (bytes_sent % 100 == 0) link_quiet = ($urandom_range(0, 3) == 0);
    if (bytes_sent >= TAIL_START) tail_phase = 1'b1;
    if (!tail_phase && !link_quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Hold the sender off until every completed message has come out.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_report(input pad_report_t want);
    if (out_left_trigger !== want.pad.left_trigger) begin
      $error("left_trigger: expected %0h, got %0h", want.pad.left_trigger, out_left_trigger);
      fail_count++;
    end
    if (out_right_trigger !== want.pad.right_trigger) begin
      $error("right_trigger: expected %0h, got %0h", want.pad.right_trigger, out_right_trigger);
      fail_count++;
    end
    if (out_left_stick_x !== want.pad.left_stick_x) begin
      $error("left_stick_x: expected %0h, got %0h", want.pad.left_stick_x, out_left_stick_x);
      fail_count++;
    end
    if (out_left_stick_y !== want.pad.left_stick_y) begin
      $error("left_stick_y: expected %0h, got %0h", want.pad.left_stick_y, out_left_stick_y);
      fail_count++;
    end
    if (out_right_stick_x !== want.pad.right_stick_x) begin
      $error("right_stick_x: expected %0h, got %0h", want.pad.right_stick_x, out_right_stick_x);
      fail_count++;
    end
    if (out_right_stick_y !== want.pad.right_stick_y) begin
      $error("right_stick_y: expected %0h, got %0h", want.pad.right_stick_y, out_right_stick_y);
      fail_count++;
    end
    if (out_direction_buttons !== want.pad.direction_buttons) begin
      $error("direction_buttons: expected %0h, got %0h",
             want.pad.direction_buttons, out_direction_buttons);
      fail_count++;
    end
    if (out_other_buttons !== want.pad.other_buttons) begin
      $error("other_buttons: expected %0h, got %0h", want.pad.other_buttons, out_other_buttons);
      fail_count++;
    end
    if (out_updated_mask !== want.mask) begin
      $error("updated_mask: expected %0h, got %0h", want.mask, out_updated_mask);
      fail_count++;
    end
  endtask

  // Result side: check accepted items, drive out_ready stalls, run the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        check_report(pending_reports.pop_front());
        reports_checked++;
      end
    end
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (rst_n && !tail_phase && !link_quiet && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned wait_cycles;
    int unsigned payload_n;
    logic [7:0]  hdr;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    out_ready    <= 1'b0;
    pad_model       = '0;
    open_mask       = '0;
    byte_pos        = '0;
    bytes_sent      = 0;
    reports_checked = 0;
    messages_sent   = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    ready_hold      = 0;
    tail_phase      = 1'b0;
    link_quiet      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
    drain_reports();

    while (bytes_sent < BYTE_GOAL) begin
      if (byte_pos == 0 && messages_sent % 150 == 149) drain_reports();
      if ($urandom_range(0, 99) < 12) begin
        // stray byte: shifts the framing of whatever follows
        send_byte(8'($urandom_range(0, 255)), 1'b0, UNTYPED);
      end else begin
        if ($urandom_range(0, 19) == 0) hdr = {2'($urandom_range(0, 3)), 6'h00};
        else hdr = 8'($urandom_range(0, 255));
        payload_n = 0;
        for (int s = 0; s < SLOT_N; s++)
          if (hdr[SLOT_HDR[s]]) payload_n++;
        send_byte(hdr, 1'b0, UNTYPED);
        repeat (payload_n) send_byte(8'($urandom_range(0, 255)), 1'b0, UNTYPED);
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_reports.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d stream bytes, %0d messages completed, %0d results checked.",
             bytes_sent, messages_sent, reports_checked);
    $display("Covered empty and ignored-bit headers, every field, misframed bytes and stalls.");
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
